// ===== rtl/xmt_pkg.sv =====
// ============================================================================
// xmt_pkg
// Types, event codes and character constants shared by the XML markup
// tokenizer modules.
// ============================================================================
package xmt_pkg;

    // Slots for the result items of one input item; one item causes at most three.
    localparam int MAX_RES = 4;
    // Width of an event code.
    localparam int EV_W = 4;
    // Width of the line number carried with each result item.
    localparam int LINE_W = 24;

    // Event codes carried by result items.
    typedef enum logic [EV_W-1:0] {
        EV_DOCSTART     = 4'd0,
        EV_DOCEND       = 4'd1,
        EV_ELEMCHAR     = 4'd2,
        EV_ELEMSTART    = 4'd3,
        EV_ELEMEND      = 4'd4,
        EV_ATTRSBEGIN   = 4'd5,
        EV_ATTRNAMECHAR = 4'd6,
        EV_ATTRVALCHAR  = 4'd7,
        EV_ATTRDONE     = 4'd8,
        EV_ATTRSEND     = 4'd9,
        EV_TEXTCHAR     = 4'd10,
        EV_TEXTDONE     = 4'd11,
        EV_LINE         = 4'd12,
        EV_ERROR        = 4'd13
    } t_event;

    // Byte-order mark and markup characters.
    localparam logic [7:0] CH_BOM0   = 8'hEF;
    localparam logic [7:0] CH_BOM1   = 8'hBB;
    localparam logic [7:0] CH_BOM2   = 8'hBF;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    // All events caused by one input item, in emission order.
    typedef struct packed {
        logic [2:0]                     cnt;
        logic [MAX_RES-1:0][EV_W-1:0]   ev;
        logic [7:0]                     ch;
        logic [LINE_W-1:0]              line_old;
        logic [LINE_W-1:0]              line_new;
    } t_bundle;

    // True for the events that carry a character.
    function automatic logic is_char_ev(input logic [EV_W-1:0] ev);
        return (ev == EV_ELEMCHAR) || (ev == EV_ATTRNAMECHAR) ||
               (ev == EV_ATTRVALCHAR) || (ev == EV_TEXTCHAR);
    endfunction

endpackage

// ===== rtl/xmt_core.sv =====
// ============================================================================
// xmt_core
// Phase machine of the tokenizer: holds the parse state and, for one input
// item, works out the next state and the list of events the item causes.
// ============================================================================
module xmt_core #(
    parameter int LINE_BITS = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output xmt_pkg::t_bundle o_bundle
);
    import xmt_pkg::*;

    // Parse phases, one-hot.
    typedef enum logic [17:0] {
        PH_START      = 18'h00001,
        PH_PROLOG     = 18'h00002,
        PH_TAG_OPEN   = 18'h00004,
        PH_ELEM_NAME  = 18'h00008,
        PH_ELEM_AFTER = 18'h00010,
        PH_ATTR_NAME  = 18'h00020,
        PH_ATTR_EQ    = 18'h00040,
        PH_ATTR_QUOTE = 18'h00080,
        PH_ATTR_VAL   = 18'h00100,
        PH_ATTR_GAP   = 18'h00200,
        PH_SELF       = 18'h00400,
        PH_CLOSE_NAME = 18'h00800,
        PH_CLOSE_GAP  = 18'h01000,
        PH_COM_OPEN   = 18'h02000,
        PH_COM_BODY   = 18'h04000,
        PH_CONTENT    = 18'h08000,
        PH_TEXT       = 18'h10000,
        PH_HALT       = 18'h20000
    } t_phase;

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_bom, n_bom;
    logic [1:0]             r_cm, n_cm;
    logic                   r_nonempty, n_nonempty;
    logic                   r_dq, n_dq;
    logic [LINE_BITS-1:0]   r_line, n_line;
    t_bundle                n_bundle;

    // Next state and the event list for the presented item.
    always_comb begin
        t_phase     ph;
        logic [7:0] c;
        logic       blank;
        logic       skip;
        logic       body;
        logic       body_attrs;
        logic [2:0] cnt;
        logic [MAX_RES-1:0][EV_W-1:0] ev;

        c          = i_byte;
        blank      = (c == CH_TAB) || (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
        skip       = 1'b0;
        body       = 1'b0;
        body_attrs = 1'b0;
        cnt        = 3'd0;
        ev         = '0;
        ph         = r_phase;
        n_phase    = r_phase;
        n_bom      = r_bom;
        n_cm       = r_cm;
        n_nonempty = r_nonempty;
        n_dq       = r_dq;
        n_line     = r_line;

        // The first item of a document opens it.
        if (r_phase == PH_START) begin
            ev[cnt[1:0]] = EV_DOCSTART; cnt = cnt + 3'd1;
            ph      = PH_PROLOG;
            n_phase = PH_PROLOG;
            n_bom   = 2'd0;
        end

        if (i_end) begin
            // End of document: flag an unfinished construct, then rewind.
            if (ph == PH_PROLOG) begin
                if (n_bom == 2'd1 || n_bom == 2'd2) begin
                    ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                end
            end else if (ph != PH_CONTENT && ph != PH_HALT) begin
                ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
            end
            ev[cnt[1:0]] = EV_DOCEND; cnt = cnt + 3'd1;
            n_phase    = PH_START;
            n_bom      = 2'd0;
            n_cm       = 2'd0;
            n_nonempty = 1'b0;
            n_dq       = 1'b0;
            n_line     = LINE_ONE;
        end else begin
            case (ph)
                PH_PROLOG: begin
                    if (n_bom == 2'd1) begin
                        if (c == CH_BOM1) begin
                            n_bom = 2'd2;
                        end else begin
                            ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    end else if (n_bom == 2'd2) begin
                        if (c == CH_BOM2) begin
                            n_bom = 2'd3;
                        end else begin
                            ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    end else if (n_bom == 2'd0 && c == CH_BOM0) begin
                        n_bom = 2'd1;
                    end else begin
                        n_bom = 2'd3;
                        if (blank) begin
                            skip = 1'b1;
                        end else if (c == CH_LT) begin
                            n_phase = PH_TAG_OPEN;
                        end else begin
                            ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    end
                end
                PH_TAG_OPEN: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else if (c == CH_SLASH) begin
                        n_nonempty = 1'b1;
                        n_phase    = PH_CLOSE_NAME;
                    end else if (c == CH_BANG) begin
                        n_cm    = 2'd0;
                        n_phase = PH_COM_OPEN;
                    end else if (c == CH_EQ || c == CH_GT) begin
                        n_nonempty = 1'b0;
                        ev[cnt[1:0]] = EV_ELEMSTART; cnt = cnt + 3'd1;
                        body = 1'b1;
                    end else begin
                        ev[cnt[1:0]] = EV_ELEMCHAR; cnt = cnt + 3'd1;
                        n_nonempty = 1'b1;
                        n_phase    = PH_ELEM_NAME;
                    end
                end
                PH_ELEM_NAME: begin
                    if (blank) begin
                        skip    = 1'b1;
                        n_phase = PH_ELEM_AFTER;
                    end else if (c == CH_EQ || c == CH_GT || (c == CH_SLASH && r_nonempty)) begin
                        ev[cnt[1:0]] = EV_ELEMSTART; cnt = cnt + 3'd1;
                        body = 1'b1;
                    end else begin
                        ev[cnt[1:0]] = EV_ELEMCHAR; cnt = cnt + 3'd1;
                    end
                end
                PH_ELEM_AFTER: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else begin
                        ev[cnt[1:0]] = EV_ELEMSTART; cnt = cnt + 3'd1;
                        body = 1'b1;
                    end
                end
                PH_ATTR_NAME: begin
                    if (blank) begin
                        skip    = 1'b1;
                        n_phase = PH_ATTR_EQ;
                    end else if (c == CH_EQ) begin
                        n_phase = PH_ATTR_QUOTE;
                    end else if (c == CH_GT || c == CH_SLASH) begin
                        ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                        n_phase = PH_HALT;
                    end else begin
                        ev[cnt[1:0]] = EV_ATTRNAMECHAR; cnt = cnt + 3'd1;
                    end
                end
                PH_ATTR_EQ: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else if (c == CH_EQ) begin
                        n_phase = PH_ATTR_QUOTE;
                    end else begin
                        ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                        n_phase = PH_HALT;
                    end
                end
                PH_ATTR_QUOTE: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        n_dq    = (c == CH_DQUOTE);
                        n_phase = PH_ATTR_VAL;
                    end else begin
                        ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                        n_phase = PH_HALT;
                    end
                end
                PH_ATTR_VAL: begin
                    if (c == (r_dq ? CH_DQUOTE : CH_SQUOTE)) begin
                        ev[cnt[1:0]] = EV_ATTRDONE; cnt = cnt + 3'd1;
                        n_phase = PH_ATTR_GAP;
                    end else begin
                        ev[cnt[1:0]] = EV_ATTRVALCHAR; cnt = cnt + 3'd1;
                    end
                end
                PH_ATTR_GAP: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else begin
                        body       = 1'b1;
                        body_attrs = 1'b1;
                    end
                end
                PH_SELF: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else begin
                        ev[cnt[1:0]] = EV_ELEMEND; cnt = cnt + 3'd1;
                        if (c == CH_GT) begin
                            n_phase = PH_CONTENT;
                        end else begin
                            ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    end
                end
                PH_CLOSE_NAME: begin
                    if (blank) begin
                        skip    = 1'b1;
                        n_phase = PH_CLOSE_GAP;
                    end else if (c == CH_GT) begin
                        ev[cnt[1:0]] = EV_ELEMEND; cnt = cnt + 3'd1;
                        n_phase = PH_CONTENT;
                    end else if (c == CH_EQ || (c == CH_SLASH && r_nonempty)) begin
                        ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                        n_phase = PH_HALT;
                    end
                end
                PH_CLOSE_GAP: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else if (c == CH_GT) begin
                        ev[cnt[1:0]] = EV_ELEMEND; cnt = cnt + 3'd1;
                        n_phase = PH_CONTENT;
                    end else begin
                        ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                        n_phase = PH_HALT;
                    end
                end
                PH_COM_OPEN: begin
                    if (r_cm < 2'd2) begin
                        if (c == CH_DASH) begin
                            n_cm = r_cm + 2'd1;
                        end else begin
                            ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    end else if (blank) begin
                        skip    = 1'b1;
                        n_cm    = 2'd0;
                        n_phase = PH_COM_BODY;
                    end else begin
                        ev[cnt[1:0]] = EV_ERROR; cnt = cnt + 3'd1;
                        n_phase = PH_HALT;
                    end
                end
                PH_COM_BODY: begin
                    // A newline in a comment counts; "-->" closes unless a third dash leads.
                    skip = (c == CH_LF);
                    if (c == CH_DASH && r_cm < 2'd2) begin
                        n_cm = r_cm + 2'd1;
                    end else if (c == CH_GT && r_cm == 2'd2) begin
                        n_cm    = 2'd0;
                        n_phase = PH_CONTENT;
                    end else begin
                        n_cm = 2'd0;
                    end
                end
                PH_CONTENT: begin
                    if (blank) begin
                        skip = 1'b1;
                    end else if (c == CH_LT) begin
                        n_phase = PH_TAG_OPEN;
                    end else begin
                        ev[cnt[1:0]] = EV_TEXTCHAR; cnt = cnt + 3'd1;
                        n_phase = PH_TEXT;
                    end
                end
                PH_TEXT: begin
                    if (c == CH_LT) begin
                        ev[cnt[1:0]] = EV_TEXTDONE; cnt = cnt + 3'd1;
                        n_phase = PH_TAG_OPEN;
                    end else begin
                        ev[cnt[1:0]] = EV_TEXTCHAR; cnt = cnt + 3'd1;
                    end
                end
                default: begin
                end
            endcase

            // Tag body after the element name or after an attribute value.
            if (body) begin
                if (c == CH_SLASH || c == CH_GT) begin
                    if (body_attrs) begin
                        ev[cnt[1:0]] = EV_ATTRSEND; cnt = cnt + 3'd1;
                    end
                    n_phase = (c == CH_SLASH) ? PH_SELF : PH_CONTENT;
                end else begin
                    if (!body_attrs) begin
                        ev[cnt[1:0]] = EV_ATTRSBEGIN; cnt = cnt + 3'd1;
                    end
                    n_nonempty = 1'b0;
                    if (c == CH_EQ) begin
                        n_phase = PH_ATTR_QUOTE;
                    end else begin
                        ev[cnt[1:0]] = EV_ATTRNAMECHAR; cnt = cnt + 3'd1;
                        n_nonempty = 1'b1;
                        n_phase    = PH_ATTR_NAME;
                    end
                end
            end

            // A skipped newline bumps the saturating line counter; it is always last.
            if (skip && c == CH_LF) begin
                if (r_line != LINE_MAX) begin
                    n_line = r_line + LINE_ONE;
                end
                ev[cnt[1:0]] = EV_LINE; cnt = cnt + 3'd1;
            end
        end

        n_bundle.cnt      = cnt;
        n_bundle.ev       = ev;
        n_bundle.ch       = c;
        n_bundle.line_old = LINE_W'(r_line);
        n_bundle.line_new = LINE_W'(n_line);
    end

    assign o_bundle = n_bundle;

    // Parse state advances once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_bom      <= 2'd0;
            r_cm       <= 2'd0;
            r_nonempty <= 1'b0;
            r_dq       <= 1'b0;
            r_line     <= LINE_ONE;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_bom      <= n_bom;
            r_cm       <= n_cm;
            r_nonempty <= n_nonempty;
            r_dq       <= n_dq;
            r_line     <= n_line;
        end
    end

endmodule

// ===== rtl/xmt_outq.sv =====
// ============================================================================
// xmt_outq
// Result register and skid slot: holds event lists and hands their events
// out one result item per cycle while the output is ready.
// ============================================================================
module xmt_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  xmt_pkg::t_bundle     i_bundle,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    output logic [xmt_pkg::EV_W-1:0]   o_event,
    output logic [7:0]                 o_char,
    output logic [xmt_pkg::LINE_W-1:0] o_line,
    output logic                       o_last
);
    import xmt_pkg::*;

    t_bundle    r_a, r_p;
    logic       r_a_valid, r_p_valid;
    logic [1:0] r_idx;
    logic [EV_W-1:0] cur_ev;
    logic       fire;
    logic       a_done;

    assign cur_ev  = r_a.ev[r_idx];
    assign o_last  = ((3'(r_idx) + 3'd1) == r_a.cnt);
    assign fire    = r_a_valid && i_out_ready;
    assign a_done  = fire && o_last;
    assign o_ready = !r_p_valid;

    // Result fields of the current event.
    assign o_valid = r_a_valid;
    assign o_event = cur_ev;
    assign o_char  = is_char_ev(cur_ev) ? r_a.ch : 8'd0;
    assign o_line  = (cur_ev == EV_LINE) ? r_a.line_new : r_a.line_old;

    // Control: the active list drains, the skid slot refills it in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_idx     <= 2'd0;
        end else if (!r_a_valid || a_done) begin
            r_idx <= 2'd0;
            if (r_p_valid) begin
                r_a_valid <= 1'b1;
                r_p_valid <= 1'b0;
            end else begin
                r_a_valid <= i_push;
            end
        end else begin
            if (fire) begin
                r_idx <= r_idx + 2'd1;
            end
            if (i_push) begin
                r_p_valid <= 1'b1;
            end
        end
    end

    // Payload of both slots.
    always_ff @(posedge i_clk) begin
        if (!r_a_valid || a_done) begin
            if (r_p_valid) begin
                r_a <= r_p;
            end else begin
                r_a <= i_bundle;
            end
        end
        if (i_push) begin
            r_p <= i_bundle;
        end
    end

endmodule

// ===== rtl/xml_markup_tokenizer_unit.sv =====
// ============================================================================
// xml_markup_tokenizer_unit
// Streaming XML tokenizer: document bytes in, SAX-style events out.
// ============================================================================
// One document byte is taken per item, and an item with tlast set ends the
// document (its byte is ignored) and rewinds the parser for the next one.
// Each item causes zero to three result items, sent one per cycle while
// the output is ready; the first is held in the output register, or in the
// skid slot while that register is busy. The input takes a new item in
// every cycle as long as each item yields at most one result and the
// output is not stalled; an item with more results can hold the input
// while its events drain, since the output register hands out a single
// result item per cycle. A skid slot holds one list while a result waits.
// ============================================================================
module xml_markup_tokenizer_unit #(
    parameter int LINE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // doc_end
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] char_out, [31:8] line_no
    output logic [3:0]  m_axis_tuser,   // [3:0] event_res
    output logic        m_axis_tlast    // last_of_run
);
    import xmt_pkg::*;

    t_bundle           bundle;
    logic              take;
    logic [EV_W-1:0]   ev;
    logic [7:0]        ch;
    logic [LINE_W-1:0] line;

    assign take = s_axis_tvalid && s_axis_tready;

    // Phase machine.
    xmt_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_bundle (bundle)
    );

    // Result register and serializer.
    xmt_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take && (bundle.cnt != 3'd0)),
        .i_bundle    (bundle),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_event     (ev),
        .o_char      (ch),
        .o_line      (line),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {line, ch};
    assign m_axis_tuser = ev;

endmodule

// ===== rtl/xmt_checker.sv =====
// ============================================================================
// xmt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ============================================================================
module xmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import xmt_pkg::*;

    // A stalled result item holds all of its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // With nothing waiting at the output the input must be open.
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output is empty");

    // End of document always closes the run of its item.
    a_docend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_DOCEND) |-> m_axis_tlast)
        else $error("docend event not last of its run");

    // Only character events carry a character.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !is_char_ev(m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("non-character event carries a character");

endmodule

bind xml_markup_tokenizer_unit xmt_checker u_xmt_checker (.*);
